// ===== sv/tps_pkg.sv =====
package tps_pkg;

   localparam int WORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MAX_VELOCITY     = 2'd0,
      CSR_MAX_ACCELERATION = 2'd1,
      CSR_TOTAL_DISTANCE   = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_ACCEL  = 2'd0,
      PH_COAST  = 2'd1,
      PH_DECEL  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

endpackage

// ===== sv/tps_div.sv =====
module tps_div #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] num_a,
   input  logic [WORD_WIDTH-1:0] den,
   output logic                  done,
   output logic [WORD_WIDTH-1:0] quo
);
   localparam int NW = WORD_WIDTH + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CW-1:0]         cnt_ff;
   logic [NW-1:0]         num_ff;
   logic [WORD_WIDTH-1:0] rem_ff;
   logic [NW-1:0]         quo_ff;
   logic [WORD_WIDTH:0]   rem_sh;
   logic [WORD_WIDTH:0]   diff;
   logic                  take;

   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign take   = rem_sh >= {1'b0, den};
   assign diff   = rem_sh - {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {num_a, {FRAC_BITS{1'b0}}};
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NW-2:0], 1'b0};
         rem_ff <= take ? diff[WORD_WIDTH-1:0] : rem_sh[WORD_WIDTH-1:0];
         quo_ff <= {quo_ff[NW-2:0], take};
      end
   end

   assign done = done_ff;
   assign quo  = (quo_ff[NW-1:WORD_WIDTH] != '0) ? {WORD_WIDTH{1'b1}} :
                 quo_ff[WORD_WIDTH-1:0];
endmodule

// ===== sv/tps_sqrt.sv =====
module tps_sqrt #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [WORD_WIDTH-1:0] radicand,
   output logic                  done,
   output logic [WORD_WIDTH-1:0] root
);
   localparam int NW = WORD_WIDTH + FRAC_BITS;
   localparam int RW = (NW + 1) / 2;
   localparam int XW = 2 * RW;
   localparam int QW = RW + 2;
   localparam int EW = (RW > WORD_WIDTH) ? RW : WORD_WIDTH;
   localparam int CW = $clog2(RW + 1);

   logic            busy_ff;
   logic            done_ff;
   logic [CW-1:0]   cnt_ff;
   logic [XW-1:0]   x_ff;
   logic [QW-1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [QW-1:0]   rem_sh;
   logic [QW-1:0]   trial;
   logic            take;
   logic [EW-1:0]   root_ext;

   assign rem_sh = {rem_ff[QW-3:0], x_ff[XW-1:XW-2]};
   assign trial  = {root_ff, 2'b01};
   assign take   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(RW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= XW'({radicand, {FRAC_BITS{1'b0}}});
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[XW-3:0], 2'b00};
         rem_ff  <= take ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[RW-2:0], take};
      end
   end

   assign root_ext = EW'(root_ff);
   assign done     = done_ff;
   assign root     = (root_ext > EW'({WORD_WIDTH{1'b1}})) ? {WORD_WIDTH{1'b1}} :
                     root_ext[WORD_WIDTH-1:0];
endmodule

// ===== sv/tps_timing.sv =====
module tps_timing #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cfg_write,
   input  logic [WORD_WIDTH-1:0] vmax,
   input  logic [WORD_WIDTH-1:0] amax,
   input  logic [WORD_WIDTH-1:0] distance,
   output logic                  timing_ok,
   output logic [WORD_WIDTH-1:0] ta,
   output logic [WORD_WIDTH-1:0] t2,
   output logic [WORD_WIDTH-1:0] tt
);
   typedef enum logic [2:0] {
      S_IDLE, S_DIV_TA, S_MUL, S_CMP, S_DIV_Q, S_SQRT, S_DIV_TC, S_SUM
   } state_type;

   localparam int PW = 2 * WORD_WIDTH;

   state_type             state_ff;
   logic                  dirty_ff;
   logic                  second_ff;
   logic                  div_start_ff;
   logic                  sqrt_start_ff;
   logic [WORD_WIDTH-1:0] div_a_ff;
   logic [WORD_WIDTH-1:0] div_b_ff;
   logic [WORD_WIDTH-1:0] ta_ff;
   logic [WORD_WIDTH-1:0] tc_ff;
   logic [WORD_WIDTH-1:0] t2_ff;
   logic [WORD_WIDTH-1:0] tt_ff;
   logic [PW-1:0]         prod_ff;
   logic [PW-1:0]         prod_sh;
   logic [WORD_WIDTH-1:0] ramp2;
   logic [WORD_WIDTH:0]   sum;
   logic [WORD_WIDTH-1:0] sum_sat;
   logic                  div_done;
   logic                  sqrt_done;
   logic [WORD_WIDTH-1:0] div_quo;
   logic [WORD_WIDTH-1:0] sqrt_root;

   tps_div #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num_a (div_a_ff),
      .den   (div_b_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   tps_sqrt #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand (div_quo),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign prod_sh = prod_ff >> FRAC_BITS;
   assign ramp2   = (prod_sh[PW-1:WORD_WIDTH] != '0) ? {WORD_WIDTH{1'b1}} :
                    prod_sh[WORD_WIDTH-1:0];
   assign sum     = second_ff ? ({1'b0, t2_ff} + {1'b0, ta_ff}) :
                                ({1'b0, ta_ff} + {1'b0, tc_ff});
   assign sum_sat = sum[WORD_WIDTH] ? {WORD_WIDTH{1'b1}} : sum[WORD_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         dirty_ff      <= 1'b1;
         second_ff     <= 1'b0;
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
      end else begin
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         if (cfg_write) begin
            dirty_ff <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (dirty_ff && !cfg_write) begin
                  dirty_ff     <= 1'b0;
                  div_a_ff     <= vmax;
                  div_b_ff     <= amax;
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV_TA;
               end
            end
            S_DIV_TA: begin
               if (div_done) begin
                  ta_ff    <= div_quo;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               prod_ff  <= PW'(ta_ff) * PW'(vmax);
               state_ff <= S_CMP;
            end
            S_CMP: begin
               div_start_ff <= 1'b1;
               if (distance < ramp2) begin
                  div_a_ff <= distance;
                  div_b_ff <= amax;
                  state_ff <= S_DIV_Q;
               end else begin
                  div_a_ff <= distance - ramp2;
                  div_b_ff <= vmax;
                  state_ff <= S_DIV_TC;
               end
            end
            S_DIV_Q: begin
               if (div_done) begin
                  sqrt_start_ff <= 1'b1;
                  state_ff      <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  ta_ff     <= sqrt_root;
                  tc_ff     <= '0;
                  second_ff <= 1'b0;
                  state_ff  <= S_SUM;
               end
            end
            S_DIV_TC: begin
               if (div_done) begin
                  tc_ff     <= div_quo;
                  second_ff <= 1'b0;
                  state_ff  <= S_SUM;
               end
            end
            S_SUM: begin
               if (!second_ff) begin
                  t2_ff     <= sum_sat;
                  second_ff <= 1'b1;
               end else begin
                  tt_ff     <= sum_sat;
                  second_ff <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign timing_ok = (state_ff == S_IDLE) && !dirty_ff && !cfg_write;
   assign ta = ta_ff;
   assign t2 = t2_ff;
   assign tt = tt_ff;
endmodule

// ===== sv/tps_pipe.sv =====
module tps_pipe #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  timing_ok,
   input  logic [WORD_WIDTH-1:0] ta,
   input  logic [WORD_WIDTH-1:0] t2,
   input  logic [WORD_WIDTH-1:0] tt,
   input  logic [WORD_WIDTH-1:0] vmax,
   input  logic [WORD_WIDTH-1:0] amax,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [WORD_WIDTH-1:0] in_time,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [WORD_WIDTH-1:0] out_vel,
   output logic [WORD_WIDTH:0]   out_acc,
   output logic [1:0]            out_phase
);
   import tps_pkg::*;

   localparam int PW = 2 * WORD_WIDTH;

   logic                  advance;
   logic                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   phase_type             s1_phase_ff, s2_phase_ff, s3_phase_ff;
   phase_type             s1_phase_in;
   logic [WORD_WIDTH-1:0] s1_op_ff;
   logic [WORD_WIDTH-1:0] s1_op_in;
   logic [PW-1:0]         s2_prod_ff;
   logic [PW-1:0]         prod_sh;
   logic [WORD_WIDTH-1:0] vel_in;
   logic [WORD_WIDTH:0]   acc_in;
   logic [WORD_WIDTH-1:0] s3_vel_ff;
   logic [WORD_WIDTH:0]   s3_acc_ff;

   assign advance  = !s3_valid_ff || out_ready;
   assign in_ready = advance && timing_ok;

   always_comb begin
      s1_op_in = in_time;
      if (in_time < ta) begin
         s1_phase_in = PH_ACCEL;
      end else if (in_time < t2) begin
         s1_phase_in = PH_COAST;
      end else if (in_time < tt) begin
         s1_phase_in = PH_DECEL;
         s1_op_in    = tt - in_time;
      end else begin
         s1_phase_in = PH_DONE;
      end
   end

   assign prod_sh = s2_prod_ff >> FRAC_BITS;

   always_comb begin
      case (s2_phase_ff)
         PH_ACCEL: begin
            acc_in = {1'b0, amax};
            vel_in = (prod_sh[PW-1:WORD_WIDTH] != '0) ? {WORD_WIDTH{1'b1}} :
                     prod_sh[WORD_WIDTH-1:0];
         end
         PH_COAST: begin
            acc_in = '0;
            vel_in = vmax;
         end
         PH_DECEL: begin
            acc_in = '0 - {1'b0, amax};
            vel_in = (prod_sh[PW-1:WORD_WIDTH] != '0) ? {WORD_WIDTH{1'b1}} :
                     prod_sh[WORD_WIDTH-1:0];
         end
         default: begin
            acc_in = '0;
            vel_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid && timing_ok;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_phase_ff <= s1_phase_in;
         s1_op_ff    <= s1_op_in;
         s2_phase_ff <= s1_phase_ff;
         s2_prod_ff  <= PW'(s1_op_ff) * PW'(amax);
         s3_phase_ff <= s2_phase_ff;
         s3_vel_ff   <= vel_in;
         s3_acc_ff   <= acc_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_vel   = s3_vel_ff;
   assign out_acc   = s3_acc_ff;
   assign out_phase = s3_phase_ff;
endmodule

// ===== sv/trapezoidal_profile_setpoint_unit.sv =====
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tdata: time_stamp
// rsp       out        rsp_tvalid/rsp_tready   tdata: velocity, acceleration; tuser: phase
// csr       in         csr_valid/csr_ready     csr_index, csr_data
//
// One transaction per cycle enters a three-stage pipeline (s1, s2, s3) unless rsp stalls or
// the phase times are being updated; its result is registered in s3 and leaves on rsp.
// After reset and after every register write, a sequencer with one shared bit-serial divider
// and a bit-serial square root works out the phase times, during which req_tready stays low.
// Reset is synchronous; a stall on rsp holds the whole pipeline.
module trapezoidal_profile_setpoint_unit #(
   parameter int WORD_WIDTH = tps_pkg::WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = tps_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((WORD_WIDTH+7)/8)*8-1:0]         req_tdata,  // time_stamp
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((2*WORD_WIDTH+8)/8)*8-1:0]       rsp_tdata,  // velocity, acceleration
   output logic [1:0]                              rsp_tuser,  // phase
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tps_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [WORD_WIDTH-1:0]                   csr_data
);
   import tps_pkg::*;

   localparam int OW = ((2*WORD_WIDTH+8)/8)*8;

   logic [WORD_WIDTH-1:0] vmax_ff, amax_ff, dist_ff;
   logic                  cfg_write;
   logic                  timing_ok;
   logic [WORD_WIDTH-1:0] ta, t2, tt;
   logic [WORD_WIDTH-1:0] out_vel;
   logic [WORD_WIDTH:0]   out_acc;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vmax_ff <= WORD_WIDTH'(1) << FRAC_BITS;
         amax_ff <= WORD_WIDTH'(1) << FRAC_BITS;
         dist_ff <= '0;
      end else if (cfg_write) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_VELOCITY:     vmax_ff <= csr_data;
            CSR_MAX_ACCELERATION: amax_ff <= csr_data;
            CSR_TOTAL_DISTANCE:   dist_ff <= csr_data;
            default: ;
         endcase
      end
   end

   tps_timing #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_timing (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (cfg_write),
      .vmax      (vmax_ff),
      .amax      (amax_ff),
      .distance  (dist_ff),
      .timing_ok (timing_ok),
      .ta        (ta),
      .t2        (t2),
      .tt        (tt)
   );

   tps_pipe #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .timing_ok (timing_ok),
      .ta        (ta),
      .t2        (t2),
      .tt        (tt),
      .vmax      (vmax_ff),
      .amax      (amax_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_time   (req_tdata[WORD_WIDTH-1:0]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_vel   (out_vel),
      .out_acc   (out_acc),
      .out_phase (rsp_tuser)
   );

   assign rsp_tdata = OW'({out_acc, out_vel});
endmodule

// ===== sv/tps_checker.sv =====
module tps_checker #(
   parameter int WORD_WIDTH = tps_pkg::WORD_WIDTH_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [2*WORD_WIDTH:0] rsp_payload,
   input logic [1:0]            rsp_tuser
);
   import tps_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == PH_DONE |-> rsp_payload == '0)
      else $error("finished move reports motion");

   a_coast_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == PH_COAST |-> rsp_payload[2*WORD_WIDTH:WORD_WIDTH] == '0)
      else $error("nonzero acceleration while coasting");

   a_accel_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == PH_ACCEL |-> !rsp_payload[2*WORD_WIDTH])
      else $error("negative acceleration while accelerating");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
endmodule

bind trapezoidal_profile_setpoint_unit tps_checker #(.WORD_WIDTH(WORD_WIDTH)) u_tps_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_payload (rsp_tdata[2*WORD_WIDTH:0]),
   .rsp_tuser   (rsp_tuser)
);

// ===== dv/tb_trapezoidal_profile_setpoint_unit.sv =====
module tb_trapezoidal_profile_setpoint_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import tps_pkg::*;

   localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;
   localparam int unsigned CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [31:0] velocity;
      logic [32:0] acceleration;
      phase_type   phase;
   } setpoint_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   logic [31:0] vmax_q = 32'h0001_0000;
   logic [31:0] amax_q = 32'h0001_0000;
   logic [31:0] dist_q = 32'h0000_0000;

   logic [31:0]  pending_stamps[$];
   setpoint_type expected_setpoints[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned results_seen = 0;
   int unsigned settings_done = 0;
   bit          calm = 1'b0;

   trapezoidal_profile_setpoint_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] sat_word(logic [63:0] x);
      return (x[63:32] != 0) ? WORD_MAX : x[31:0];
   endfunction

   function automatic logic [31:0] fix_mul(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return sat_word(p >> 16);
   endfunction

   function automatic logic [31:0] fix_div(logic [31:0] a, logic [31:0] b);
      logic [63:0] n;
      n = {32'd0, a} << 16;
      if (b == 0) return WORD_MAX;
      return sat_word(n / {32'd0, b});
   endfunction

   function automatic logic [31:0] fix_sqrt(logic [31:0] a);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] c;
      x = {32'd0, a} << 16;
      r = 0;
      for (int i = 24; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if (c * c <= x) r = c;
      end
      return r[31:0];
   endfunction

   function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      return sat_word({32'd0, a} + {32'd0, b});
   endfunction

   function automatic void phase_times(output logic [31:0] ta, output logic [31:0] t2,
                                       output logic [31:0] tt);
      logic [31:0] ramp2;
      logic [31:0] tc;
      ta = fix_div(vmax_q, amax_q);
      ramp2 = fix_mul(ta, vmax_q);
      if (dist_q < ramp2) begin
         ta = fix_sqrt(fix_div(dist_q, amax_q));
         tc = 0;
      end else begin
         tc = fix_div(dist_q - ramp2, vmax_q);
      end
      t2 = sat_sum(ta, tc);
      tt = sat_sum(t2, ta);
   endfunction

   function automatic setpoint_type profile_at(logic [31:0] t);
      setpoint_type s;
      logic [31:0] ta, t2, tt;
      phase_times(ta, t2, tt);
      if (t < ta) begin
         s.phase = PH_ACCEL;
         s.velocity = fix_mul(t, amax_q);
         s.acceleration = {1'b0, amax_q};
      end else if (t < t2) begin
         s.phase = PH_COAST;
         s.velocity = vmax_q;
         s.acceleration = '0;
      end else if (t < tt) begin
         s.phase = PH_DECEL;
         s.velocity = fix_mul(tt - t, amax_q);
         s.acceleration = 33'd0 - {1'b0, amax_q};
      end else begin
         s.phase = PH_DONE;
         s.velocity = '0;
         s.acceleration = '0;
      end
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
               results_seen);
      mismatches++;
   endtask

   always @(posedge clock) begin
      logic        next_valid;
      logic [31:0] next_data;
      next_valid = req_tvalid;
      next_data = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_setpoints.push_back(profile_at(req_tdata));
            next_valid = 1'b0;
         end
         if (!next_valid && pending_stamps.size() != 0 &&
             (calm || $urandom_range(0, 99) >= 34)) begin
            next_valid = 1'b1;
            next_data = pending_stamps.pop_front();
         end
      end
      req_tvalid <= next_valid;
      req_tdata <= next_data;
   end

   always @(posedge clock) begin
      setpoint_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_setpoints.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[63:0], 64'd0);
         end else begin
            want = expected_setpoints.pop_front();
            if (rsp_tdata[31:0] !== want.velocity)
               report_mismatch("velocity", 64'(rsp_tdata[31:0]), 64'(want.velocity));
            if (rsp_tdata[64:32] !== want.acceleration)
               report_mismatch("acceleration", 64'(rsp_tdata[64:32]),
                               64'(want.acceleration));
            if (rsp_tuser !== want.phase)
               report_mismatch("phase", 64'(rsp_tuser), 64'(want.phase));
         end
      end
      rsp_tready <= calm || ($urandom_range(0, 99) >= 34);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("trapezoidal_profile_setpoint_unit test failed");
         $finish;
      end
   end

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_stamps.size() != 0 || req_tvalid || expected_setpoints.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_VELOCITY:     vmax_q = value;
         CSR_MAX_ACCELERATION: amax_q = value;
         CSR_TOTAL_DISTANCE:   dist_q = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] v, logic [31:0] a, logic [31:0] d);
      wait_idle();
      write_csr(CSR_MAX_VELOCITY, v);
      write_csr(CSR_MAX_ACCELERATION, a);
      write_csr(CSR_TOTAL_DISTANCE, d);
      write_csr(CSR_UNUSED, $urandom);
      settings_done++;
   endtask

   function automatic logic [31:0] scaled_word();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   task automatic push_boundaries();
      logic [31:0] ta, t2, tt;
      phase_times(ta, t2, tt);
      pending_stamps.push_back(0);
      pending_stamps.push_back(WORD_MAX);
      pending_stamps.push_back(ta - 1);
      pending_stamps.push_back(ta);
      pending_stamps.push_back(t2 - 1);
      pending_stamps.push_back(t2);
      pending_stamps.push_back(tt - 1);
      pending_stamps.push_back(tt);
   endtask

   task automatic push_random(int count);
      logic [31:0] ta, t2, tt;
      logic [31:0] t;
      phase_times(ta, t2, tt);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: t = $urandom;
            1: t = scaled_word();
            2: t = (tt == 0) ? $urandom : $urandom_range(0, tt);
            default: begin
               case ($urandom_range(0, 2))
                  0: t = ta;
                  1: t = t2;
                  default: t = tt;
               endcase
               t = t + $urandom_range(0, 6) - 3;
            end
         endcase
         pending_stamps.push_back(t);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      push_boundaries();
      pending_stamps.push_back(32'h0000_8000);
      configure(32'h0001_0000, 32'h0001_0000, 32'h0004_0000);
      push_boundaries();
      configure(WORD_MAX, 32'd1, WORD_MAX);
      push_boundaries();
      configure(32'd1, WORD_MAX, WORD_MAX);
      push_boundaries();
      configure(32'd0, 32'h0001_0000, 32'h0010_0000);
      push_boundaries();
      configure(32'h0002_0000, 32'd0, 32'h0010_0000);
      push_boundaries();

      for (int phase_n = 0; phase_n < 12; phase_n++) begin
         configure(scaled_word(), scaled_word(), scaled_word());
         calm = (phase_n == 5);
         push_boundaries();
         push_random(45);
         wait_idle();
         push_random(40);
      end
      calm = 1'b0;

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d register settings and %0d results, incl. triangular,",
               settings_done, results_seen);
      $display("saturated, zero-divisor and phase-boundary time stamps.");
      if (mismatches == 0) begin
         $display("trapezoidal_profile_setpoint_unit test passed");
      end else begin
         $display("trapezoidal_profile_setpoint_unit test failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
sv/tps_pkg.sv
sv/tps_div.sv
sv/tps_sqrt.sv
sv/tps_timing.sv
sv/tps_pipe.sv
sv/trapezoidal_profile_setpoint_unit.sv
sv/tps_checker.sv
dv/tb_trapezoidal_profile_setpoint_unit.sv
